@@ sv/c8ie_pkg.sv @@
`default_nettype none
package c8ie_pkg;
	localparam int unsigned DISPLAY_W = 64;
	localparam int unsigned DISPLAY_H = 32;
	localparam int unsigned RAM_DEPTH = 4096;
	localparam int unsigned ADDR_W    = 12;
	localparam int unsigned ROW_W     = 5;
	localparam int unsigned IN_W      = 48;
	localparam int unsigned OUT_W     = 80;

	localparam logic [ADDR_W-1:0] PC_RESET   = 12'd512;
	localparam logic [ADDR_W-1:0] FONT_RESET = 12'd80;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_EXEC  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_ROW   = 2'd3
	} action_t;

	// top opcode nibble
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEK  = 4'h3;
	localparam logic [3:0] OP_SNEK = 4'h4;
	localparam logic [3:0] OP_SEV  = 4'h5;
	localparam logic [3:0] OP_LDK  = 4'h6;
	localparam logic [3:0] OP_ADDK = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNEV = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] FX_GETDT = 8'h07;
	localparam logic [7:0] FX_WAITK = 8'h0A;
	localparam logic [7:0] FX_SETDT = 8'h15;
	localparam logic [7:0] FX_SETST = 8'h18;
	localparam logic [7:0] FX_ADDI  = 8'h1E;
	localparam logic [7:0] FX_FONT  = 8'h29;
	localparam logic [7:0] FX_BCD   = 8'h33;
	localparam logic [7:0] FX_SAVE  = 8'h55;
	localparam logic [7:0] FX_LOAD  = 8'h65;
endpackage
`default_nettype wire

@@ sv/chip8_instruction_executor.sv @@
`default_nettype none
// CHIP-8 core: each request writes or reads a RAM byte, reads a display row, or runs one
// instruction. An instruction passes through accept, two fetch reads, two register reads,
// execute and result, plus a read and a write per sprite row drawn and a closing step for the
// draw, three writes for BCD, a write per register V0..VX for FX55 and a read and a write per
// register for FX65, all through the RAM. The result stage may also wait while an earlier
// result is not yet taken. The input is ready only between requests; one result stage lets
// the next request start while the last result is still waiting.
module chip8_instruction_executor
	import c8ie_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [11:0]      cfg_wr_data,   // font_base
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // address, write_data, keys_down_mask, last_key
	input  wire logic [1:0]       s_axis_tuser,  // action
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata   // read_data, pc_out, waiting_for_key,
	                                             // collision, sound_active
);
	localparam int unsigned SP_W = $clog2(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_MRD, S_F1, S_F2, S_RX, S_RY, S_EXEC,
		S_DRD, S_DWR, S_BCD, S_SAVE, S_LRD, S_LWR, S_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] font_q, pc_q;
	logic [15:0]       idx_q, keys_q;
	logic [4:0]        lkey_q;
	logic [7:0]        regs_q [16];
	logic [SP_W-1:0]   sp_q;
	logic [DISPLAY_W-1:0] disp_q [DISPLAY_H];
	logic [7:0]        dt_q, st_q, vx_q, vy_q;
	logic [15:0]       ins_q;
	logic [3:0]        cnt_q;
	logic              hit_q, coll_q, wait_q;
	logic [63:0]       rdata_q;
	logic [3:0]        dig_q [3];

	logic [7:0]        mem [RAM_DEPTH];
	logic [7:0]        mem_q;
	logic [ADDR_W-1:0] stack [STACK_DEPTH];
	logic [ADDR_W-1:0] stk_q;

	logic              accept;
	logic [ADDR_W-1:0] raddr, waddr;
	logic              we;
	logic [7:0]        wdata;
	logic              stk_we;
	logic [SP_W-1:0]   sp_dec, sp_inc;
	logic [3:0]        op, x, y, n;
	logic [7:0]        kk;
	logic [ADDR_W-1:0] npc2, npc4, ptr;
	logic [5:0]        row;
	logic [63:0]       bits;
	logic [7:0]        rem100;
	logic [14:0]       tens_prod;
	logic [ADDR_W-1:0] next_pc;
	state_t            exec_next;
	logic [7:0]        alu_res, alu_flag;
	logic              alu_we, alu_fwe;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign op = ins_q[15:12];
	assign x  = ins_q[11:8];
	assign y  = ins_q[7:4];
	assign n  = ins_q[3:0];
	assign kk = ins_q[7:0];
	assign npc2 = pc_q + 12'd2;
	assign npc4 = pc_q + 12'd4;
	assign ptr  = idx_q[ADDR_W-1:0] + {8'd0, cnt_q};
	assign row  = {1'b0, vy_q[4:0]} + {2'd0, cnt_q};
	assign bits = {mem_q, 56'd0} >> vx_q[5:0];
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	// bcd: hundreds by compare, tens by reciprocal multiply (exact below 100)
	assign rem100 = (vx_q >= 8'd200) ? vx_q - 8'd200 :
	                (vx_q >= 8'd100) ? vx_q - 8'd100 : vx_q;
	assign tens_prod = 15'(rem100[6:0]) * 15'd103;

	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = ptr;
		wdata = regs_q[cnt_q];
		stk_we = (state_q == S_EXEC) && (op == OP_CALL);
		unique case (state_q)
			S_IDLE: begin
				raddr = (s_axis_tuser == ACT_EXEC) ? pc_q : s_axis_tdata[11:0];
				we = accept && (s_axis_tuser == ACT_WRITE);
				waddr = s_axis_tdata[11:0];
				wdata = s_axis_tdata[19:12];
			end
			S_F1: raddr = pc_q + 12'd1;
			S_DRD, S_LRD: raddr = ptr;
			S_BCD: begin
				we = 1'b1;
				wdata = {4'd0, dig_q[cnt_q[1:0]]};
			end
			S_SAVE: we = 1'b1;
			default: raddr = '0;
		endcase
	end

	// next program counter and follow-on state of the execute step
	always_comb begin
		next_pc = npc2;
		exec_next = S_DONE;
		case (op)
			OP_SYS:  if (ins_q == INS_RET) next_pc = stk_q;
			OP_JP:   next_pc = ins_q[11:0];
			OP_CALL: next_pc = ins_q[11:0];
			OP_SEK:  if (vx_q == kk) next_pc = npc4;
			OP_SNEK: if (vx_q != kk) next_pc = npc4;
			OP_SEV:  if (vx_q == vy_q) next_pc = npc4;
			OP_SNEV: if (vx_q != vy_q) next_pc = npc4;
			OP_JPV0: next_pc = {4'd0, vx_q} + ins_q[11:0];
			OP_DRW:  exec_next = S_DRD;
			OP_KEY: begin
				if ((kk == KEY_DOWN && keys_q[vx_q[3:0]]) ||
				    (kk == KEY_UP && !keys_q[vx_q[3:0]]))
					next_pc = npc4;
			end
			OP_MISC: begin
				case (kk)
					FX_WAITK: if (lkey_q[4]) next_pc = pc_q;
					FX_BCD:   exec_next = S_BCD;
					FX_SAVE:  exec_next = S_SAVE;
					FX_LOAD:  exec_next = S_LRD;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		alu_res = vy_q;
		alu_flag = 8'd0;
		alu_we = 1'b1;
		alu_fwe = 1'b1;
		case (n)
			ALU_MOV: alu_fwe = 1'b0;
			ALU_OR:  alu_res = vx_q | vy_q;
			ALU_AND: alu_res = vx_q & vy_q;
			ALU_XOR: alu_res = vx_q ^ vy_q;
			ALU_ADD: begin
				alu_res = vx_q + vy_q;
				alu_flag = {7'd0, (9'(vx_q) + 9'(vy_q)) > 9'd255};
			end
			ALU_SUB: begin
				alu_res = vx_q - vy_q;
				alu_flag = {7'd0, vx_q >= vy_q};
			end
			ALU_SHR: begin
				alu_res = vy_q >> 1;
				alu_flag = {7'd0, vy_q[0]};
			end
			ALU_SBN: begin
				alu_res = vy_q - vx_q;
				alu_flag = {7'd0, vy_q >= vx_q};
			end
			ALU_SHL: begin
				alu_res = vy_q << 1;
				alu_flag = {7'd0, vy_q[7]};
			end
			default: begin
				alu_we = 1'b0;
				alu_fwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		mem_q <= mem[raddr];
		if (stk_we)
			stack[sp_q] <= npc2;
		stk_q <= stack[sp_dec];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			font_q <= FONT_RESET;
			pc_q <= PC_RESET;
			idx_q <= '0;
			sp_q <= '0;
			dt_q <= '0;
			st_q <= '0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			for (int i = 0; i < DISPLAY_H; i++) disp_q[i] <= '0;
		end else begin
			if (cfg_wr_en)
				font_q <= cfg_wr_data;
			if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready))
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					keys_q <= s_axis_tdata[35:20];
					lkey_q <= s_axis_tdata[40:36];
					rdata_q <= (action_t'(s_axis_tuser) == ACT_ROW &&
					            s_axis_tdata[11:ROW_W] == '0) ?
					           disp_q[s_axis_tdata[ROW_W-1:0]] : '0;
					wait_q <= 1'b0;
					coll_q <= 1'b0;
					unique case (action_t'(s_axis_tuser))
						ACT_WRITE: state_q <= S_DONE;
						ACT_READ:  state_q <= S_MRD;
						ACT_EXEC:  state_q <= S_F1;
						ACT_ROW:   state_q <= S_DONE;
					endcase
				end
				S_MRD: begin
					rdata_q <= {56'd0, mem_q};
					state_q <= S_DONE;
				end
				S_F1: begin
					ins_q[15:8] <= mem_q;
					state_q <= S_F2;
				end
				S_F2: begin
					ins_q[7:0] <= mem_q;
					state_q <= S_RX;
				end
				S_RX: begin
					vx_q <= regs_q[(op == OP_JPV0) ? 4'd0 : x];
					state_q <= S_RY;
				end
				S_RY: begin
					vy_q <= regs_q[y];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pc_q <= next_pc;
					cnt_q <= '0;
					hit_q <= 1'b0;
					state_q <= exec_next;
					case (op)
						OP_SYS: begin
							if (ins_q == INS_CLS)
								for (int i = 0; i < DISPLAY_H; i++) disp_q[i] <= '0;
							else if (ins_q == INS_RET)
								sp_q <= sp_dec;
						end
						OP_CALL: sp_q <= sp_inc;
						OP_LDK:  regs_q[x] <= kk;
						OP_ADDK: regs_q[x] <= vx_q + kk;
						OP_ALU: begin
							// vf keeps the flag rather than the result when x is f and the op sets a flag
							if (alu_we && !(alu_fwe && x == 4'hF))
								regs_q[x] <= alu_res;
							if (alu_fwe)
								regs_q[15] <= alu_flag;
						end
						OP_LDI:  idx_q <= {4'd0, ins_q[11:0]};
						OP_MISC: begin
							case (kk)
								FX_GETDT: regs_q[x] <= dt_q;
								FX_WAITK: begin
									if (!lkey_q[4])
										regs_q[x] <= {4'd0, lkey_q[3:0]};
									wait_q <= lkey_q[4];
								end
								FX_SETDT: dt_q <= vx_q;
								FX_SETST: st_q <= vx_q;
								FX_ADDI:  idx_q <= idx_q + {8'd0, vx_q};
								FX_FONT:  idx_q <= {4'd0, font_q} +
								                   {10'd0, vx_q[3:0], 2'd0} + {12'd0, vx_q[3:0]};
								FX_BCD: begin
									dig_q[0] <= (vx_q >= 8'd200) ? 4'd2 :
									            (vx_q >= 8'd100) ? 4'd1 : 4'd0;
									dig_q[1] <= tens_prod[13:10];
									dig_q[2] <= 4'(rem100 - {4'd0, tens_prod[13:10]} * 8'd10);
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_DRD: begin
					if (cnt_q < n && !row[5])
						state_q <= S_DWR;
					else begin
						regs_q[15] <= {7'd0, hit_q};
						coll_q <= hit_q;
						state_q <= S_DONE;
					end
				end
				S_DWR: begin
					if ((disp_q[row[4:0]] & bits) != '0)
						hit_q <= 1'b1;
					disp_q[row[4:0]] <= disp_q[row[4:0]] ^ bits;
					cnt_q <= cnt_q + 4'd1;
					state_q <= S_DRD;
				end
				S_BCD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2)
						state_q <= S_DONE;
				end
				S_SAVE: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == x) begin
						idx_q <= idx_q + {12'd0, x} + 16'd1;
						state_q <= S_DONE;
					end
				end
				S_LRD: state_q <= S_LWR;
				S_LWR: begin
					regs_q[cnt_q] <= mem_q;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == x) begin
						idx_q <= idx_q + {12'd0, x} + 16'd1;
						state_q <= S_DONE;
					end else
						state_q <= S_LRD;
				end
				S_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tdata <= {1'b0, (st_q != 8'd0), coll_q, wait_q, pc_q, rdata_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sp_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(sp_q))
		else $error("stack pointer moved outside execute");

	pc_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(pc_q))
		else $error("program counter moved outside execute");

	wait_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op == OP_MISC && kk == FX_WAITK && lkey_q[4])
		|=> (pc_q == $past(pc_q) && wait_q))
		else $error("key wait advanced the program counter");

	busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !s_axis_tready)
		else $error("input ready while executing");
endmodule
`default_nettype wire
